[src/ssae_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package ssae_pkg;

    localparam int SET_DEPTH = 16;
    localparam int IDX_W     = (SET_DEPTH > 1) ? $clog2(SET_DEPTH) : 1;
    localparam int CNT_W     = $clog2(SET_DEPTH + 1);

    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(SET_DEPTH);

    typedef enum logic [2:0] {
        OP_INS_A  = 3'd0,
        OP_INS_B  = 3'd1,
        OP_CLEAR  = 3'd2,
        OP_UNION  = 3'd3,
        OP_INTER  = 3'd4,
        OP_DIFF   = 3'd5,
        OP_CMP    = 3'd6
    } op_t;

    typedef enum logic [2:0] {
        ST_STORED  = 3'd0,
        ST_DUP     = 3'd1,
        ST_FULL    = 3'd2,
        ST_ELEM    = 3'd3,
        ST_EMPTY   = 3'd4,
        ST_EQUAL   = 3'd5,
        ST_UNEQUAL = 3'd6,
        ST_CLEARED = 3'd7
    } status_t;

endpackage
`default_nettype wire

[src/small_set_algebra_engine.sv]
// Operation: insert scans its own set, then stores the value; clear zeroes both counts;
//   compare matches the counts, then scans B for each A entry; intersection and difference
//   scan B per A entry; union lists A, then checks B against A; a stalled output holds them.
// Throughput: one request at a time; the nested scan reads one entry per cycle
//   through the single read port of each set memory.
// Reset: synchronous, active low; clears counts, control and output valid; memories kept.
`timescale 1ns / 1ps
`default_nettype none
module small_set_algebra_engine
    import ssae_pkg::*;
(
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic [2:0]         s_op,
    input  wire logic signed [31:0] s_value,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic [2:0]              m_status,
    output logic signed [31:0]      m_element,
    output logic                    m_last
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_OFETCH,
        S_OLOAD,
        S_SCAN,
        S_PUSH,
        S_DONE,
        S_FINAL
    } state_t;

    logic [31:0] mem_a [SET_DEPTH];
    logic [31:0] mem_b [SET_DEPTH];
    logic [31:0] rd_a_reg, rd_b_reg;

    state_t            state_reg, state_next;
    logic [2:0]        op_reg, op_next;
    logic [31:0]       key_reg, key_next;
    logic [CNT_W-1:0]  i_reg, i_next;
    logic [CNT_W-1:0]  j_reg, j_next;
    logic [CNT_W-1:0]  cnt_a_reg, cnt_a_next;
    logic [CNT_W-1:0]  cnt_b_reg, cnt_b_next;
    logic              phase_reg, phase_next;
    logic              scan_v_reg, scan_v_next;
    logic              held_v_reg, held_v_next;
    logic [31:0]       held_reg, held_next;
    status_t           final_reg, final_next;
    logic              m_valid_reg, m_valid_next;
    status_t           m_status_reg, m_status_next;
    logic [31:0]       m_element_reg, m_element_next;
    logic              m_last_reg, m_last_next;

    logic              out_free;
    logic              outer_b, inner_a, list_mode;
    logic [CNT_W-1:0]  cnt_outer, cnt_inner;
    logic [31:0]       rdata_inner, rdata_outer;
    logic [IDX_W-1:0]  addr_a, addr_b, wr_addr;
    logic              hit, scan_end;
    logic              we_a, we_b;

    assign out_free    = !m_valid_reg || m_ready;
    assign outer_b     = (op_reg == OP_UNION) && phase_reg;
    assign list_mode   = (op_reg == OP_UNION) && !phase_reg;
    // insert scans its own set; union second pass checks B entries against A
    assign inner_a     = (op_reg == OP_INS_A) || (op_reg == OP_UNION);
    assign cnt_outer   = outer_b ? cnt_b_reg : cnt_a_reg;
    assign cnt_inner   = inner_a ? cnt_a_reg : cnt_b_reg;
    assign rdata_inner = inner_a ? rd_a_reg : rd_b_reg;
    assign rdata_outer = outer_b ? rd_b_reg : rd_a_reg;
    assign addr_a      = (state_reg == S_SCAN && inner_a)  ? j_reg[IDX_W-1:0] : i_reg[IDX_W-1:0];
    assign addr_b      = (state_reg == S_SCAN && !inner_a) ? j_reg[IDX_W-1:0] : i_reg[IDX_W-1:0];
    assign wr_addr     = cnt_inner[IDX_W-1:0];

    // scan_v_reg marks that the read data belongs to the entry issued last cycle
    assign hit      = scan_v_reg && (rdata_inner == key_reg);
    assign scan_end = !hit && (j_reg >= cnt_inner);

    assign we_a = (state_reg == S_SCAN) && (op_reg == OP_INS_A) && scan_end
                  && (cnt_a_reg < DEPTH_CNT);
    assign we_b = (state_reg == S_SCAN) && (op_reg == OP_INS_B) && scan_end
                  && (cnt_b_reg < DEPTH_CNT);

    always_ff @(posedge aclk) begin
        if (we_a) begin
            mem_a[wr_addr] <= key_reg;
        end
        rd_a_reg <= mem_a[addr_a];
    end

    always_ff @(posedge aclk) begin
        if (we_b) begin
            mem_b[wr_addr] <= key_reg;
        end
        rd_b_reg <= mem_b[addr_b];
    end

    assign s_ready   = (state_reg == S_IDLE);
    assign m_valid   = m_valid_reg;
    assign m_status  = m_status_reg;
    assign m_element = m_element_reg;
    assign m_last    = m_last_reg;

    always_comb begin
        state_next     = state_reg;
        op_next        = op_reg;
        key_next       = key_reg;
        i_next         = i_reg;
        j_next         = j_reg;
        cnt_a_next     = cnt_a_reg;
        cnt_b_next     = cnt_b_reg;
        phase_next     = phase_reg;
        scan_v_next    = scan_v_reg;
        held_v_next    = held_v_reg;
        held_next      = held_reg;
        final_next     = final_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        m_status_next  = m_status_reg;
        m_element_next = m_element_reg;
        m_last_next    = m_last_reg;

        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    op_next     = s_op;
                    key_next    = s_value;
                    i_next      = '0;
                    j_next      = '0;
                    phase_next  = 1'b0;
                    scan_v_next = 1'b0;
                    held_v_next = 1'b0;
                    case (s_op)
                        OP_INS_A, OP_INS_B: begin
                            state_next = S_SCAN;
                        end
                        OP_CLEAR: begin
                            cnt_a_next = '0;
                            cnt_b_next = '0;
                            final_next = ST_CLEARED;
                            state_next = S_FINAL;
                        end
                        OP_UNION, OP_INTER, OP_DIFF: begin
                            state_next = S_OFETCH;
                        end
                        OP_CMP: begin
                            if (cnt_a_reg != cnt_b_reg) begin
                                final_next = ST_UNEQUAL;
                                state_next = S_FINAL;
                            end else begin
                                state_next = S_OFETCH;
                            end
                        end
                        default: begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_OFETCH: begin
                if (i_reg < cnt_outer) begin
                    state_next = S_OLOAD;
                end else if (list_mode) begin
                    phase_next = 1'b1;
                    i_next     = '0;
                end else if (op_reg == OP_CMP) begin
                    final_next = ST_EQUAL;
                    state_next = S_FINAL;
                end else begin
                    state_next = S_DONE;
                end
            end
            S_OLOAD: begin
                key_next = rdata_outer;
                i_next   = i_reg + 1'b1;
                if (list_mode) begin
                    state_next = S_PUSH;
                end else begin
                    j_next      = '0;
                    scan_v_next = 1'b0;
                    state_next  = S_SCAN;
                end
            end
            S_SCAN: begin
                if (hit || scan_end) begin
                    scan_v_next = 1'b0;
                    case (op_reg)
                        OP_INS_A, OP_INS_B: begin
                            state_next = S_FINAL;
                            if (hit) begin
                                final_next = ST_DUP;
                            end else if (cnt_inner >= DEPTH_CNT) begin
                                final_next = ST_FULL;
                            end else begin
                                final_next = ST_STORED;
                                if (op_reg == OP_INS_A) begin
                                    cnt_a_next = cnt_a_reg + 1'b1;
                                end else begin
                                    cnt_b_next = cnt_b_reg + 1'b1;
                                end
                            end
                        end
                        OP_CMP: begin
                            if (hit) begin
                                state_next = S_OFETCH;
                            end else begin
                                final_next = ST_UNEQUAL;
                                state_next = S_FINAL;
                            end
                        end
                        OP_INTER: begin
                            state_next = hit ? S_PUSH : S_OFETCH;
                        end
                        default: begin
                            state_next = hit ? S_OFETCH : S_PUSH;
                        end
                    endcase
                end else begin
                    j_next      = j_reg + 1'b1;
                    scan_v_next = 1'b1;
                end
            end
            S_PUSH: begin
                // one element is held back so the final one can carry last
                if (!held_v_reg) begin
                    held_next   = key_reg;
                    held_v_next = 1'b1;
                    state_next  = S_OFETCH;
                end else if (out_free) begin
                    m_valid_next   = 1'b1;
                    m_status_next  = ST_ELEM;
                    m_element_next = held_reg;
                    m_last_next    = 1'b0;
                    held_next      = key_reg;
                    state_next     = S_OFETCH;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_last_next  = 1'b1;
                    if (held_v_reg) begin
                        m_status_next  = ST_ELEM;
                        m_element_next = held_reg;
                    end else begin
                        m_status_next  = ST_EMPTY;
                        m_element_next = '0;
                    end
                    held_v_next = 1'b0;
                    state_next  = S_IDLE;
                end
            end
            S_FINAL: begin
                if (out_free) begin
                    m_valid_next   = 1'b1;
                    m_status_next  = final_reg;
                    m_element_next = '0;
                    m_last_next    = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            cnt_a_reg   <= '0;
            cnt_b_reg   <= '0;
            phase_reg   <= 1'b0;
            scan_v_reg  <= 1'b0;
            held_v_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_a_reg   <= cnt_a_next;
            cnt_b_reg   <= cnt_b_next;
            phase_reg   <= phase_next;
            scan_v_reg  <= scan_v_next;
            held_v_reg  <= held_v_next;
            m_valid_reg <= m_valid_next;
        end
        op_reg        <= op_next;
        key_reg       <= key_next;
        i_reg         <= i_next;
        j_reg         <= j_next;
        held_reg      <= held_next;
        final_reg     <= final_next;
        m_status_reg  <= m_status_next;
        m_element_reg <= m_element_next;
        m_last_reg    <= m_last_next;
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (cnt_a_reg <= DEPTH_CNT) && (cnt_b_reg <= DEPTH_CNT))
        else $error("set count beyond depth");

    a_nonlast_is_elem: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_last_reg) |-> (m_status_reg == ST_ELEM))
        else $error("non-final result without element status");

    a_held_stream_only: assert property (@(posedge aclk) disable iff (!aresetn)
        (held_v_reg && state_reg != S_IDLE) |->
            (op_reg == OP_UNION || op_reg == OP_INTER || op_reg == OP_DIFF))
        else $error("held element outside a streaming query");

    a_scan_valid_in_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        scan_v_reg |-> (state_reg == S_SCAN))
        else $error("scan read pending outside scan");

    a_single_write: assert property (@(posedge aclk) disable iff (!aresetn)
        !(we_a && we_b))
        else $error("both set memories written at once");
`endif

endmodule
`default_nettype wire
